FILE: src/urt_pkg.sv
// Shared types and constants for the ultrasonic range timer.
`timescale 1ns / 1ps

package urt_pkg;

    localparam int unsigned MIN_PERIOD = 32'd12240000;

    localparam int unsigned TICKS_W = 24;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned SCALE_W = 24;
    localparam int unsigned PCNT_W  = 32;
    localparam int unsigned IN_W    = 8;
    localparam int unsigned OUT_W   = 48;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CFG_W   = 32;

    localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

    localparam logic [31:0]        RST_REPEAT_PERIOD = 32'd20400000;
    localparam logic [15:0]        RST_TRIGGER_WIDTH = 16'd2040;
    localparam logic [TICKS_W-1:0] RST_WINDOW_LIMIT  = 24'd7752000;
    localparam logic [SCALE_W-1:0] RST_MM_PER_TICK   = 24'd13981;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TRIG   = 2'd1,
        PH_LISTEN = 2'd2,
        PH_WAIT   = 2'd3
    } phase_t;

    typedef enum logic [IDX_W-1:0] {
        REG_CONTINUOUS_MODE = 3'd0,
        REG_REPEAT_PERIOD   = 3'd1,
        REG_TRIGGER_WIDTH   = 3'd2,
        REG_WINDOW_LIMIT    = 3'd3,
        REG_MM_PER_TICK     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic               continuous_mode;
        logic [31:0]        repeat_period;
        logic [15:0]        trigger_width;
        logic [TICKS_W-1:0] window_limit;
        logic [SCALE_W-1:0] mm_per_tick_q24;
    } urt_cfg_t;

    typedef struct packed {
        logic               trigger_level;
        logic               is_listening;
        logic               measure_done;
        logic               reliable;
        logic [TICKS_W-1:0] echo_ticks;
    } urt_flags_t;

endpackage

FILE: src/urt_ctrl.sv
// Phase sequencer and echo pulse timer, one step per accepted tick.
`timescale 1ns / 1ps

module urt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               echo_level,
    input  logic               start_request,
    input  urt_pkg::urt_cfg_t  cfg,
    output urt_pkg::urt_flags_t flags
);

    urt_pkg::phase_t               phase_reg, phase_next;
    logic [urt_pkg::PCNT_W-1:0]    phase_cnt_reg, phase_cnt_next;
    logic [urt_pkg::TICKS_W-1:0]   echo_cnt_reg, echo_cnt_next;
    logic                          echo_seen_reg, echo_seen_next;
    logic [urt_pkg::TICKS_W-1:0]   last_ticks_reg, last_ticks_next;
    logic                          last_rel_reg, last_rel_next;
    logic                          done_next;

    logic [urt_pkg::PCNT_W-1:0]    tw;
    logic [urt_pkg::PCNT_W-1:0]    wl;
    logic [urt_pkg::PCNT_W-1:0]    period;
    logic [urt_pkg::PCNT_W-1:0]    pcnt_inc;

    // Zero width or window counts as one tick.
    assign tw = (cfg.trigger_width == '0) ? urt_pkg::PCNT_W'(1)
                                          : urt_pkg::PCNT_W'(cfg.trigger_width);
    assign wl = (cfg.window_limit == '0) ? urt_pkg::PCNT_W'(1)
                                         : urt_pkg::PCNT_W'(cfg.window_limit);
    assign period = (cfg.repeat_period > urt_pkg::MIN_PERIOD) ? cfg.repeat_period
                                                              : urt_pkg::MIN_PERIOD;
    assign pcnt_inc = phase_cnt_reg + urt_pkg::PCNT_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        phase_cnt_next  = phase_cnt_reg;
        echo_cnt_next   = echo_cnt_reg;
        echo_seen_next  = echo_seen_reg;
        last_ticks_next = last_ticks_reg;
        last_rel_next   = last_rel_reg;
        done_next       = 1'b0;
        unique case (phase_reg)
            urt_pkg::PH_IDLE:
            begin
                if (start_request)
                begin
                    phase_next     = urt_pkg::PH_TRIG;
                    phase_cnt_next = urt_pkg::PCNT_W'(1);
                    last_rel_next  = 1'b0;
                    echo_cnt_next  = '0;
                    echo_seen_next = 1'b0;
                end
                else if (cfg.continuous_mode)
                begin
                    phase_next     = urt_pkg::PH_WAIT;
                    phase_cnt_next = '0;
                end
            end
            urt_pkg::PH_TRIG:
            begin
                if (phase_cnt_reg >= tw)
                begin
                    phase_next     = urt_pkg::PH_LISTEN;
                    phase_cnt_next = '0;
                end
                else
                begin
                    phase_cnt_next = pcnt_inc;
                end
            end
            urt_pkg::PH_LISTEN:
            begin
                if (echo_level)
                begin
                    echo_seen_next = 1'b1;
                    if (echo_cnt_reg != urt_pkg::TICKS_MAX)
                    begin
                        echo_cnt_next = echo_cnt_reg + urt_pkg::TICKS_W'(1);
                    end
                end
                else if (echo_seen_reg)
                begin
                    // Falling edge: latch the pulse width.
                    last_ticks_next = echo_cnt_reg;
                    last_rel_next   = (urt_pkg::PCNT_W'(echo_cnt_reg) < wl);
                    done_next       = 1'b1;
                    echo_cnt_next   = '0;
                    echo_seen_next  = 1'b0;
                end
                phase_cnt_next = pcnt_inc;
                if (pcnt_inc >= wl)
                begin
                    // Window closes; drop any unfinished pulse.
                    echo_cnt_next  = '0;
                    echo_seen_next = 1'b0;
                    phase_cnt_next = '0;
                    phase_next     = cfg.continuous_mode ? urt_pkg::PH_WAIT
                                                         : urt_pkg::PH_IDLE;
                end
            end
            urt_pkg::PH_WAIT:
            begin
                if (!cfg.continuous_mode)
                begin
                    phase_next     = urt_pkg::PH_IDLE;
                    phase_cnt_next = '0;
                end
                else if (pcnt_inc >= period)
                begin
                    phase_next     = urt_pkg::PH_TRIG;
                    phase_cnt_next = urt_pkg::PCNT_W'(1);
                    last_rel_next  = 1'b0;
                    echo_cnt_next  = '0;
                    echo_seen_next = 1'b0;
                end
                else
                begin
                    phase_cnt_next = pcnt_inc;
                end
            end
            default:
            begin
                phase_next = urt_pkg::PH_IDLE;
            end
        endcase
    end

    // Result fields show the state after this tick.
    always_comb
    begin
        flags.trigger_level = (phase_next == urt_pkg::PH_TRIG);
        flags.is_listening  = (phase_next == urt_pkg::PH_LISTEN);
        flags.measure_done  = done_next;
        flags.reliable      = last_rel_next;
        flags.echo_ticks    = last_ticks_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= urt_pkg::PH_IDLE;
            phase_cnt_reg  <= '0;
            echo_cnt_reg   <= '0;
            echo_seen_reg  <= 1'b0;
            last_ticks_reg <= '0;
            last_rel_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            phase_cnt_reg  <= phase_cnt_next;
            echo_cnt_reg   <= echo_cnt_next;
            echo_seen_reg  <= echo_seen_next;
            last_ticks_reg <= last_ticks_next;
            last_rel_reg   <= last_rel_next;
        end
    end

endmodule

FILE: src/ultrasonic_range_timer.sv
// Top level of the ultrasonic range timer: config registers, pipeline, distance scaling.
`timescale 1ns / 1ps
//
// Each request on the slave stream is one tick of the ranging timebase and
// carries the echo pin level and a start request. Every request produces
// exactly one result on the master stream: trigger and listen levels, a
// pulse-done strobe, the reliable flag, the last echo width in ticks and the
// distance in mm ((ticks * mm_per_tick_q24) >> 24, saturated to 16 bits).
// The phase state advances once per accepted request.
// The sequencer result is registered at accept in the stage-one register; the
// 24x24 distance multiply fills the output register once it is free.
// Unstalled throughput is one request per cycle; two register stages let a new
// request in while a result waits. A stall on m_tready holds the output
// register, then the stage-one register, and only then drops s_tready.
// The config port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; writes take effect at once and are meant for idle periods.
// Indexes 0..4: continuous_mode, repeat_period, trigger_width,
// window_limit, mm_per_tick_q24; other indexes are ignored.
// Reset (rst_n low, asynchronous) restores the default registers, puts the
// sequencer in idle and empties both pipeline stages.

module ultrasonic_range_timer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [urt_pkg::IN_W-1:0]          s_tdata,   // [0] echo_level, [1] start_request
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] trigger_level, [1] is_listening, [2] measure_done, [3] reliable,
    // [27:4] echo_ticks, [43:28] distance_mm
    output logic [urt_pkg::OUT_W-1:0]         m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [urt_pkg::IDX_W-1:0]         cfg_index,
    input  logic [urt_pkg::CFG_W-1:0]         cfg_data
);

    urt_pkg::urt_cfg_t                     cfg_reg;
    urt_pkg::urt_flags_t                   flags;
    urt_pkg::urt_flags_t                   s1_flags_reg;
    logic [urt_pkg::SCALE_W-1:0]           s1_mm_reg;
    logic                                  s1_valid_reg;
    logic                                  out_valid_reg;
    logic [urt_pkg::OUT_W-1:0]             out_data_reg;
    logic                                  accept;
    logic                                  adv2;
    logic [urt_pkg::TICKS_W+urt_pkg::SCALE_W-1:0] product;
    logic [urt_pkg::DIST_W-1:0]            dist_mm;

    assign cfg_ready = 1'b1;
    assign adv2      = !out_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || adv2;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.continuous_mode <= 1'b0;
            cfg_reg.repeat_period   <= urt_pkg::RST_REPEAT_PERIOD;
            cfg_reg.trigger_width   <= urt_pkg::RST_TRIGGER_WIDTH;
            cfg_reg.window_limit    <= urt_pkg::RST_WINDOW_LIMIT;
            cfg_reg.mm_per_tick_q24 <= urt_pkg::RST_MM_PER_TICK;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                urt_pkg::REG_CONTINUOUS_MODE: cfg_reg.continuous_mode <= cfg_data[0];
                urt_pkg::REG_REPEAT_PERIOD:   cfg_reg.repeat_period   <= cfg_data;
                urt_pkg::REG_TRIGGER_WIDTH:   cfg_reg.trigger_width   <= cfg_data[15:0];
                urt_pkg::REG_WINDOW_LIMIT:
                    cfg_reg.window_limit <= cfg_data[urt_pkg::TICKS_W-1:0];
                urt_pkg::REG_MM_PER_TICK:
                    cfg_reg.mm_per_tick_q24 <= cfg_data[urt_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    urt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .echo_level    (s_tdata[0]),
        .start_request (s_tdata[1]),
        .cfg           (cfg_reg),
        .flags         (flags)
    );

    // Stage one: sequencer result and the scale in force for this tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv2)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= flags;
            s1_mm_reg    <= cfg_reg.mm_per_tick_q24;
        end
    end

    // Stage two: scale ticks to mm and saturate.
    assign product = s1_flags_reg.echo_ticks * s1_mm_reg;
    assign dist_mm = (product[urt_pkg::TICKS_W+urt_pkg::SCALE_W-1:
                              urt_pkg::SCALE_W+urt_pkg::DIST_W] != '0)
                     ? {urt_pkg::DIST_W{1'b1}}
                     : product[urt_pkg::SCALE_W+urt_pkg::DIST_W-1:urt_pkg::SCALE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv2)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_valid_reg)
        begin
            out_data_reg <= {4'b0000, dist_mm, s1_flags_reg.echo_ticks,
                             s1_flags_reg.reliable, s1_flags_reg.measure_done,
                             s1_flags_reg.is_listening, s1_flags_reg.trigger_level};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: src/urt_checker.sv
// Port-level checks for the ultrasonic range timer, bound to the top level.
`timescale 1ns / 1ps

module urt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [urt_pkg::OUT_W-1:0]   m_tdata
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Trigger and listen phases never overlap.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("trigger and listen both high");

    // A finished pulse is at least one tick wide.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[27:4] != '0)
        else $error("measure done with zero echo ticks");

    // Zero width means zero distance; reliable needs a real pulse.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[27:4] == '0 |-> m_tdata[43:28] == '0 && !m_tdata[3])
        else $error("distance or reliable flag without echo ticks");

endmodule

bind ultrasonic_range_timer urt_checker u_urt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
